### rtl/core/tlvd_pkg.sv
`timescale 1ns / 1ps

package tlvd_pkg;

   localparam int unsigned HEADER_BYTES = 8;
   localparam int unsigned COUNT_W      = 4;

   localparam logic [COUNT_W-1:0] HEADER_LAST = COUNT_W'(HEADER_BYTES - 1);
   localparam logic [COUNT_W-1:0] HEADER_DONE = COUNT_W'(HEADER_BYTES);

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_IDX_MAX_LEN   = 1'b0;

   typedef enum logic [1:0] {
      ST_HEADER   = 2'd0,
      ST_VALUE    = 2'd1,
      ST_OVERSIZE = 2'd2,
      ST_REJECTED = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] value_offset;
      logic [31:0] value_length;
      logic [31:0] message_type;
      logic [7:0]  value_byte;
   } rsp_data_type;

endpackage

### rtl/core/tlv_message_deframer.sv
`timescale 1ns / 1ps

// Type-length-value deframer for a byte stream. Each message opens with an
// eight-byte header (big-endian 32-bit type, then big-endian 32-bit length);
// the following value bytes come out tagged with type, length and offset, and
// the byte that ends a message carries tlast. A length above the max_value_length
// register (address 0x0, reset 0xFFFFFFFF) gives one oversize result and every
// later item is rejected until reset. One item is taken every clock cycle while
// rsp_tready keeps the result register free; each result passes through the single
// decode stage between the input register and the result register.
module tlv_message_deframer (
   input  logic                               clock,
   input  logic                               reset,
   // data_byte
   input  logic [7:0]                         req_tdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // value_byte, message_type, value_length, value_offset
   output logic [103:0]                       rsp_tdata,
   // status
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tlvd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import tlvd_pkg::*;

   logic [31:0]        max_len_ff;
   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff, rsp_data_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0] hdr_count_ff, hdr_count_in;
   logic [55:0]        hdr_shift_ff, hdr_shift_in;
   logic [31:0]        cur_type_ff, cur_type_in;
   logic [31:0]        cur_len_ff, cur_len_in;
   logic [31:0]        rx_count_ff, rx_count_in;
   logic               error_ff, error_in;

   logic               out_load;
   logic               process;
   logic [63:0]        full_hdr;
   logic [31:0]        rx_next;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_load;
   assign process    = in_valid_ff && out_load;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_LEN) ? max_len_ff : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign full_hdr = {hdr_shift_ff, in_byte_ff};
   assign rx_next  = rx_count_ff + 32'd1;

   always_comb begin
      hdr_count_in  = hdr_count_ff;
      hdr_shift_in  = hdr_shift_ff;
      cur_type_in   = cur_type_ff;
      cur_len_in    = cur_len_ff;
      rx_count_in   = rx_count_ff;
      error_in      = error_ff;
      rsp_data_in   = '0;
      rsp_status_in = ST_HEADER;
      rsp_last_in   = 1'b0;
      if (error_ff) begin
         rsp_status_in            = ST_REJECTED;
         rsp_data_in.message_type = cur_type_ff;
         rsp_data_in.value_length = cur_len_ff;
      end else if (hdr_count_ff != HEADER_DONE) begin
         hdr_shift_in = full_hdr[55:0];
         hdr_count_in = hdr_count_ff + COUNT_W'(1);
         if (hdr_count_ff == HEADER_LAST) begin
            cur_type_in              = full_hdr[63:32];
            cur_len_in               = full_hdr[31:0];
            rx_count_in              = 32'd0;
            rsp_data_in.message_type = full_hdr[63:32];
            rsp_data_in.value_length = full_hdr[31:0];
            if (full_hdr[31:0] > max_len_ff) begin
               error_in      = 1'b1;
               rsp_status_in = ST_OVERSIZE;
            end else if (full_hdr[31:0] == 32'd0) begin
               rsp_last_in  = 1'b1;
               hdr_count_in = '0;
            end
         end
      end else begin
         rsp_status_in            = ST_VALUE;
         rsp_data_in.value_byte   = in_byte_ff;
         rsp_data_in.message_type = cur_type_ff;
         rsp_data_in.value_length = cur_len_ff;
         rsp_data_in.value_offset = rx_count_ff;
         rx_count_in              = rx_next;
         if (rx_next == cur_len_ff) begin
            rsp_last_in  = 1'b1;
            hdr_count_in = '0;
            rx_count_in  = 32'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= 32'hFFFF_FFFF;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hdr_count_ff <= '0;
         rx_count_ff  <= 32'd0;
         error_ff     <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == CSR_IDX_MAX_LEN) begin
            max_len_ff <= csr_pwdata;
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_load) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (process) begin
            hdr_count_ff <= hdr_count_in;
            rx_count_ff  <= rx_count_in;
            error_ff     <= error_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (process) begin
         hdr_shift_ff  <= hdr_shift_in;
         cur_type_ff   <= cur_type_in;
         cur_len_ff    <= cur_len_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

endmodule

### rtl/core/tlvd_checker.sv
`timescale 1ns / 1ps

module tlvd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic [103:0]                    rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);
   import tlvd_pkg::*;

   logic err_seen_ff;

   // sticky once an oversize or rejected item has gone out
   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready
                   && (rsp_tuser == ST_OVERSIZE || rsp_tuser == ST_REJECTED)) begin
         err_seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && err_seen_ff |-> rsp_tuser == ST_REJECTED)
      else $error("item after error not rejected");

   a_last_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == ST_HEADER || rsp_tuser == ST_VALUE)
      else $error("last on an error item");

   a_non_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_VALUE |-> rsp_tdata[7:0] == 8'd0
         && rsp_tdata[103:72] == 32'd0)
      else $error("byte or offset set on a non-value item");

endmodule

bind tlv_message_deframer tlvd_checker u_tlvd_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
   import tlvd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] MAX_LEN_ADDR = CSR_ADDR_W'(4 * CSR_IDX_MAX_LEN);
   localparam logic [CSR_ADDR_W-1:0] UNUSED_ADDR  = CSR_ADDR_W'(4 * (CSR_IDX_MAX_LEN + 1));
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 300;

   typedef struct packed {
      status_type   status;
      logic         last;
      rsp_data_type data;
   } deframe_result_type;

   typedef struct {
      logic [7:0]         data;
      bit                 fixed;
      deframe_result_type res;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic [7:0]            req_tdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [103:0]          rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // sideband travelling with each offered item
   bit                 req_fixed;
   deframe_result_type req_fixed_res;

   // predictor state
   logic [COUNT_W-1:0] hdr_cnt;
   logic [63:0]        hdr_shift;
   logic [31:0]        cur_type;
   logic [31:0]        cur_len;
   logic [31:0]        val_cnt;
   logic               oversize_seen;
   logic [31:0]        max_len_reg;

   deframe_result_type pending_results[$];
   stim_row_type       dir_rows[$];
   int                 dir_open;
   int                 error_count;
   int                 items_sent;
   int                 quiet_cycles;
   bit                 idle_on;
   bit                 long_hold;

   tlv_message_deframer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic deframe_result_type deframe_byte(input logic [7:0] b);
      deframe_result_type r;
      r = '0;
      if (oversize_seen) begin
         r.status = ST_REJECTED;
         r.data.message_type = cur_type;
         r.data.value_length = cur_len;
         return r;
      end
      if (hdr_cnt < HEADER_DONE) begin
         hdr_shift = {hdr_shift[55:0], b};
         hdr_cnt = hdr_cnt + 1'b1;
         if (hdr_cnt < HEADER_DONE) begin
            r.status = ST_HEADER;
            return r;
         end
         cur_type = hdr_shift[63:32];
         cur_len  = hdr_shift[31:0];
         val_cnt  = '0;
         r.data.message_type = cur_type;
         r.data.value_length = cur_len;
         if (cur_len > max_len_reg) begin
            oversize_seen = 1'b1;
            r.status = ST_OVERSIZE;
            return r;
         end
         r.status = ST_HEADER;
         if (cur_len == '0) begin
            r.last    = 1'b1;
            hdr_cnt   = '0;
            hdr_shift = '0;
         end
         return r;
      end
      r.status = ST_VALUE;
      r.data.value_byte   = b;
      r.data.message_type = cur_type;
      r.data.value_length = cur_len;
      r.data.value_offset = val_cnt;
      val_cnt = val_cnt + 32'd1;
      r.last = (val_cnt == cur_len);
      if (r.last) begin
         hdr_cnt   = '0;
         hdr_shift = '0;
         val_cnt   = '0;
      end
      return r;
   endfunction

   // item acceptance, prediction and comparison
   always @(posedge clock) begin
      deframe_result_type want;
      deframe_result_type got;
      if (!reset && req_tvalid && req_tready) begin
         want = deframe_byte(req_tdata);
         if (req_fixed) begin
            want = req_fixed_res;
         end
         pending_results.push_back(want);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = deframe_result_type'({rsp_tuser, rsp_tlast, rsp_tdata});
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected item st=%0d last=%0d byte=%02h %s",
                     $time, got.status, got.last, got.data.value_byte,
                     $sformatf("type=%08h len=%08h off=%08h", got.data.message_type,
                               got.data.value_length, got.data.value_offset));
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected st=%0d last=%0d byte=%02h %s",
                        $time, want.status, want.last, want.data.value_byte,
                        $sformatf("type=%08h len=%08h off=%08h",
                                  want.data.message_type, want.data.value_length,
                                  want.data.value_offset));
               $display("%0t:          actual st=%0d last=%0d byte=%02h %s",
                        $time, got.status, got.last, got.data.value_byte,
                        $sformatf("type=%08h len=%08h off=%08h",
                                  got.data.message_type, got.data.value_length,
                                  got.data.value_offset));
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
            long_hold = 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit fx,
                            input deframe_result_type res);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tdata     <= b;
      req_fixed     <= fx;
      req_fixed_res <= res;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] d);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (a == MAX_LEN_ADDR) begin
         max_len_reg = d;
      end
   endtask

   task automatic csr_check();
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= MAX_LEN_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== max_len_reg) begin
         $display("%0t: max_value_length read expected %08h actual %08h",
                  $time, max_len_reg, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_message(input logic [31:0] ty, input logic [31:0] ln);
      logic [63:0] hdr;
      hdr = {ty, ln};
      for (int i = 7; i >= 0; i--) begin
         send_byte(hdr[8*i +: 8], 1'b0, '0);
      end
      for (int i = 0; i < ln; i++) begin
         send_byte(8'($urandom), 1'b0, '0);
      end
   endtask

   task automatic run_phase(input logic [31:0] max_len, input int budget, input int cap,
                            input bit hold);
      int          stop_at;
      int unsigned top;
      int unsigned ln;
      settle();
      csr_write(MAX_LEN_ADDR, max_len);
      csr_check();
      top = (max_len < cap) ? max_len : cap;
      stop_at = items_sent + budget;
      long_hold = hold;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 7))
            0: ln = 0;
            1: ln = top;
            default: ln = $urandom_range(0, top);
         endcase
         send_message($urandom, ln);
      end
   endtask

   task automatic add_row(input logic [7:0] d, input bit fx, input status_type st,
                          input logic [31:0] ty, input logic [31:0] ln, input bit lst);
      stim_row_type row;
      row.data = d;
      row.fixed = fx;
      row.res = '0;
      row.res.status = st;
      row.res.last = lst;
      row.res.data.message_type = ty;
      row.res.data.value_length = ln;
      dir_rows.push_back(row);
   endtask

   initial begin
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_fixed     <= 1'b0;
      req_fixed_res <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      hdr_cnt       = '0;
      hdr_shift     = '0;
      cur_type      = '0;
      cur_len       = '0;
      val_cnt       = '0;
      oversize_seen = 1'b0;
      max_len_reg   = 32'hFFFF_FFFF;
      error_count   = 0;
      items_sent    = 0;
      quiet_cycles  = 0;
      idle_on       = 1'b1;
      long_hold     = 1'b0;

      // zero-length message with the most negative type
      add_row(8'h80, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'h8000_0000, 32'd0, 1'b1);
      // most positive type, two value bytes
      add_row(8'h7F, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'hFF, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'hFF, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'hFF, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b1, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h02, 1'b1, ST_HEADER, 32'h7FFF_FFFF, 32'd2, 1'b0);
      add_row(8'hFF, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h00, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      dir_open = dir_rows.size();
      // largest length above the limit, then rejection
      add_row(8'h12, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h34, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h56, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'h78, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'hFF, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'hFF, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'hFF, 1'b0, ST_HEADER, 32'd0, 32'd0, 1'b0);
      add_row(8'hFF, 1'b1, ST_OVERSIZE, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
      add_row(8'hFF, 1'b1, ST_REJECTED, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
      add_row(8'h00, 1'b1, ST_REJECTED, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_check();

      for (int k = 0; k < dir_open; k++) begin
         send_byte(dir_rows[k].data, dir_rows[k].fixed, dir_rows[k].res);
      end

      run_phase(32'hFFFF_FFFF, 400, 24, 1'b1);
      run_phase(32'd7, 300, 7, 1'b0);
      settle();
      csr_write(UNUSED_ADDR, $urandom);
      csr_check();
      run_phase(32'd0, 150, 0, 1'b0);
      run_phase($urandom_range(16, 40), 300, 40, 1'b0);
      idle_on = 1'b0;
      run_phase(32'hFFFF_FFFF, 200, 24, 1'b0);

      settle();
      csr_write(MAX_LEN_ADDR, 32'hFFFF_FFFE);
      csr_check();
      for (int k = dir_open; k < dir_rows.size(); k++) begin
         send_byte(dir_rows[k].data, dir_rows[k].fixed, dir_rows[k].res);
      end
      repeat (40) send_byte(8'($urandom), 1'b0, '0);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
